### design/rpa_pkg.sv
package rpa_pkg;

  localparam int FRAME_W             = 20;
  localparam int NUM_PAGES_DEFAULT   = 4096;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_FREE  = 3'd1;
  localparam logic [2:0] REQ_INC   = 3'd2;
  localparam logic [2:0] REQ_DEC   = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_UNDER = 3'd3;
  localparam logic [2:0] ST_OVF   = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [FRAME_W-1:0] frame_number;
  } rpa_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] alloc_frame;
    logic [15:0]        ref_count;
    logic               page_freed;
    logic [12:0]        free_count;
  } rpa_rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } rpa_state_t;

endpackage

### design/refcounted_page_allocator_core.sv
// A word is accepted in S_IDLE, where its fields and the count and link reads
// are registered; in S_EXEC the memories are written back and the result word
// is loaded once the output register is free. in_ready stays low until then.
// Reset: synchronous; the count memory is then cleared one entry a cycle, with
// in_ready low. Config writes are taken throughout.
module refcounted_page_allocator_core #(
  parameter int NUM_PAGES   = rpa_pkg::NUM_PAGES_DEFAULT,
  parameter int COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rpa_pkg::FRAME_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rpa_pkg::rpa_req_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rpa_pkg::rpa_rsp_t            out_data
);
  import rpa_pkg::*;

  localparam int IW  = $clog2(NUM_PAGES);
  localparam int PFW = $clog2(NUM_PAGES + 1);
  localparam logic [PFW-1:0]         PF_FULL  = PFW'(NUM_PAGES);
  localparam logic [FRAME_W:0]       NP_EXT   = (FRAME_W + 1)'(NUM_PAGES);
  localparam logic [IW-1:0]          IDX_LAST = IW'(NUM_PAGES - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] ref_mem [NUM_PAGES];
  logic [IW-1:0]          link_mem [NUM_PAGES];

  rpa_state_t             state, state_next;
  logic [FRAME_W-1:0]     base_frame;
  logic [IW-1:0]          head, head_next;
  logic [PFW-1:0]         pages_free, pages_free_next;
  logic [IW-1:0]          clr_addr;
  logic [2:0]             req_q;
  logic                   in_range_q;
  logic [IW-1:0]          idx_q;
  logic [COUNT_WIDTH-1:0] ref_q;
  logic [IW-1:0]          link_q;

  logic                   accept;
  logic [FRAME_W:0]       diff;
  logic                   in_range;
  logic                   ref_we;
  logic [IW-1:0]          ref_waddr;
  logic [COUNT_WIDTH-1:0] ref_wdata;
  logic                   link_we;
  logic                   out_load;
  logic                   push;
  logic [2:0]             status;
  logic [FRAME_W-1:0]     alloc_frame;
  logic [COUNT_WIDTH-1:0] cnt;
  logic                   freed;
  logic [31:0]            cnt_ext;
  logic [31:0]            pf_ext;

  assign accept   = in_valid && in_ready;
  assign diff     = {1'b0, in_data.frame_number} - {1'b0, base_frame};
  assign in_range = !diff[FRAME_W] && (diff < NP_EXT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      base_frame <= '0;
      head       <= '0;
      pages_free <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      pages_free <= pages_free_next;
      if (cfg_we) begin
        base_frame <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= in_data.req_type;
      in_range_q <= in_range;
      idx_q      <= diff[IW-1:0];
      ref_q      <= ref_mem[diff[IW-1:0]];
      link_q     <= link_mem[head];
    end
    if (out_load) begin
      out_data.status      <= status;
      out_data.alloc_frame <= alloc_frame;
      out_data.ref_count   <= cnt_ext[15:0];
      out_data.page_freed  <= freed;
      out_data.free_count  <= pf_ext[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (link_we) begin
      link_mem[idx_q] <= head;
    end
  end

  assign cnt_ext = 32'(cnt);
  assign pf_ext  = 32'(pages_free_next);

  always_comb begin
    state_next      = state;
    head_next       = head;
    pages_free_next = pages_free;
    in_ready        = 1'b0;
    out_load        = 1'b0;
    ref_we          = 1'b0;
    ref_waddr       = idx_q;
    ref_wdata       = '0;
    link_we         = 1'b0;
    push            = 1'b0;
    status          = ST_OK;
    alloc_frame     = '0;
    cnt             = '0;
    freed           = 1'b0;

    unique case (state)
      S_CLEAR: begin
        ref_we    = 1'b1;
        ref_waddr = clr_addr;
        if (clr_addr == IDX_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_q == REQ_ALLOC) begin
          if (pages_free == '0) begin
            status = ST_EMPTY;
          end else begin
            ref_we          = 1'b1;
            ref_waddr       = head;
            ref_wdata       = CNT_ONE;
            head_next       = link_q;
            pages_free_next = pages_free - PFW'(1);
            alloc_frame     = base_frame + FRAME_W'(head);
            cnt             = CNT_ONE;
          end
        end else if (!in_range_q) begin
          status = ST_RANGE;
        end else begin
          case (req_q)
            REQ_FREE: begin
              if (ref_q > CNT_ONE) begin
                ref_we    = 1'b1;
                ref_wdata = ref_q - CNT_ONE;
                cnt       = ref_q - CNT_ONE;
              end else begin
                push = 1'b1;
              end
            end
            REQ_INC: begin
              if (ref_q == CNT_MAX) begin
                status = ST_OVF;
                cnt    = ref_q;
              end else begin
                ref_we    = 1'b1;
                ref_wdata = ref_q + CNT_ONE;
                cnt       = ref_q + CNT_ONE;
              end
            end
            REQ_DEC: begin
              if (ref_q == '0) begin
                status = ST_UNDER;
              end else if (ref_q == CNT_ONE) begin
                push = 1'b1;
              end else begin
                ref_we    = 1'b1;
                ref_wdata = ref_q - CNT_ONE;
                cnt       = ref_q - CNT_ONE;
              end
            end
            default: begin
              cnt = ref_q;
            end
          endcase
          if (push) begin
            ref_we    = 1'b1;
            ref_wdata = '0;
            if (pages_free == PF_FULL) begin
              status = ST_OVF;
            end else begin
              link_we         = 1'b1;
              head_next       = idx_q;
              pages_free_next = pages_free + PFW'(1);
              freed           = 1'b1;
            end
          end
        end
        // hold until the output register can take the word
        if (out_valid && !out_ready) begin
          state_next      = S_EXEC;
          head_next       = head;
          pages_free_next = pages_free;
          ref_we          = 1'b0;
          link_we         = 1'b0;
        end else begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sim/refcounted_page_allocator_core_tb.sv
`timescale 1ns / 100ps

module refcounted_page_allocator_core_tb;
  import rpa_pkg::*;

  localparam int          POOL_PAGES = NUM_PAGES_DEFAULT;
  localparam int unsigned COUNT_MAX  = (1 << COUNT_WIDTH_DEFAULT) - 1;
  localparam logic [19:0] BASE_TOP   = 20'hFFFFF;
  localparam int          LONG_HOLD  = 400;
  localparam int          IDLE_LIMIT = 20000;
  localparam int          PRINT_CAP  = 30;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  logic [19:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  rpa_req_t  in_data;
  logic      out_valid;
  logic      out_ready;
  rpa_rsp_t  out_data;

  // page pool shadow
  int unsigned page_refs [POOL_PAGES];
  logic [11:0] page_link [POOL_PAGES];
  bit          link_set  [POOL_PAGES];
  logic [11:0] head_page;
  int          pages_free;
  logic [19:0] pool_base;

  rpa_rsp_t answers_due [$];

  int  mismatches;
  int  words_sent;
  int  results_seen;
  int  allocs_granted;
  int  pages_pushed;
  int  base_writes;
  int  quiet_cycles;
  bit  req_jitter;
  bit  rsp_jitter;
  bit  rsp_hold_req;

  refcounted_page_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic bit push_page(input logic [11:0] idx);
    page_refs[idx] = 0;
    if (pages_free >= POOL_PAGES) return 1'b0;
    page_link[idx] = head_page;
    link_set[idx] = 1'b1;
    head_page = idx;
    pages_free++;
    pages_pushed++;
    return 1'b1;
  endfunction

  function automatic rpa_rsp_t apply_page_request(input rpa_req_t w);
    rpa_rsp_t    a;
    logic [19:0] off;
    logic [11:0] idx;
    int unsigned c;
    a = '0;
    off = w.frame_number - pool_base;
    if (w.req_type == REQ_ALLOC) begin
      if (pages_free == 0) begin
        a.status = ST_EMPTY;
      end else begin
        idx = head_page;
        head_page = page_link[idx];
        pages_free--;
        page_refs[idx] = 1;
        a.alloc_frame = pool_base + {8'd0, idx};
        a.ref_count = 16'd1;
        allocs_granted++;
      end
    end else if (w.frame_number < pool_base || off >= POOL_PAGES) begin
      a.status = ST_RANGE;
    end else begin
      idx = off[11:0];
      c = page_refs[idx];
      case (w.req_type)
        REQ_FREE: begin
          if (c > 1) page_refs[idx] = c - 1;
          else if (push_page(idx)) a.page_freed = 1'b1;
          else a.status = ST_OVF;
        end
        REQ_INC: begin
          if (c >= COUNT_MAX) a.status = ST_OVF;
          else page_refs[idx] = c + 1;
        end
        REQ_DEC: begin
          if (c == 0) begin
            a.status = ST_UNDER;
          end else begin
            page_refs[idx] = c - 1;
            if (c == 1) begin
              if (push_page(idx)) a.page_freed = 1'b1;
              else a.status = ST_OVF;
            end
          end
        end
        default: ;
      endcase
      a.ref_count = page_refs[idx][15:0];
    end
    a.free_count = pages_free[12:0];
    return a;
  endfunction

  // an allocate must never lead the next pop onto a link that was never written
  function automatic bit pop_is_safe();
    return pages_free <= 1 || link_set[page_link[head_page]];
  endfunction

  function automatic int pick_gap(input bit jitter);
    int r;
    if (!jitter) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic [2:0] kind, input logic [19:0] frame);
    rpa_req_t w;
    int       gap;
    w.req_type = kind;
    w.frame_number = frame;
    gap = pick_gap(req_jitter);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    answers_due.push_back(apply_page_request(w));
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_base(input logic [19:0] b);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_base = b;
    base_writes++;
  endtask

  task automatic send_random_word();
    int          r;
    logic [2:0]  kind;
    logic [19:0] frame;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      kind = 3'($urandom_range(0, 7));
      frame = 20'($urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) kind = REQ_ALLOC;
      else if (r < 50) kind = REQ_FREE;
      else if (r < 65) kind = REQ_INC;
      else if (r < 85) kind = REQ_DEC;
      else if (r < 95) kind = REQ_QUERY;
      else kind = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 75) frame = pool_base + 20'($urandom_range(0, 31));
      else if (r < 92) frame = pool_base + 20'($urandom_range(0, POOL_PAGES - 1));
      else if (r < 97) frame = pool_base + 20'($urandom_range(POOL_PAGES - 8, POOL_PAGES - 1));
      else if (r < 99) frame = pool_base - 20'd1;
      else frame = pool_base + 20'(POOL_PAGES);
    end
    if (kind == REQ_ALLOC && !pop_is_safe()) kind = REQ_QUERY;
    send_word(kind, frame);
  endtask

  task automatic test_directed_edges();
    logic [19:0] b;
    b = 20'h00100;
    req_jitter = 1'b1;
    rsp_jitter = 1'b1;
    set_base(b);
    send_word(REQ_ALLOC, 20'd0);
    send_word(REQ_QUERY, 20'd0);
    send_word(REQ_QUERY, b - 20'd1);
    send_word(REQ_QUERY, b + 20'(POOL_PAGES));
    send_word(REQ_FREE, BASE_TOP);
    send_word(REQ_QUERY, b);
    send_word(REQ_DEC, b);
    send_word(REQ_INC, b + 20'd2);
    send_word(3'd5, b + 20'd2);
    send_word(3'd7, b + 20'd2);
    send_word(3'd6, 20'd0);
    send_word(REQ_FREE, b + 20'd1);
    send_word(REQ_FREE, b + 20'(POOL_PAGES - 1));
    send_word(REQ_FREE, b);
    send_word(REQ_ALLOC, 20'd0);
    send_word(REQ_ALLOC, 20'd0);
    send_word(REQ_ALLOC, 20'd0);
    send_word(REQ_ALLOC, 20'd0);
    send_word(REQ_INC, b + 20'd1);
    send_word(REQ_FREE, b + 20'd1);
    send_word(REQ_DEC, b + 20'd1);
    send_word(REQ_FREE, b + 20'd2);
    send_word(REQ_INC, b + 20'(POOL_PAGES - 1));
    send_word(REQ_DEC, b + 20'(POOL_PAGES - 1));
    drain();
  endtask

  task automatic test_output_backpressure();
    int i;
    set_base(20'($urandom_range(1, BASE_TOP - POOL_PAGES)));
    req_jitter = 1'b0;
    rsp_jitter = 1'b0;
    rsp_hold_req = 1'b1;
    for (i = 0; i < 24; i++) send_random_word();
    drain();
  endtask

  task automatic test_random_mix();
    logic [19:0] bases [4];
    int          quota [4];
    int          p;
    int          i;
    bases[0] = 20'd0;
    bases[1] = 20'($urandom_range(1, BASE_TOP - POOL_PAGES));
    bases[2] = BASE_TOP - 20'(POOL_PAGES - 1);
    bases[3] = BASE_TOP;
    quota[0] = 280;
    quota[1] = 280;
    quota[2] = 250;
    quota[3] = 100;
    for (p = 0; p < 4; p++) begin
      set_base(bases[p]);
      for (i = 0; i < quota[p]; i++) begin
        req_jitter = (i >= 30);
        rsp_jitter = (i >= 30);
        send_random_word();
      end
    end
    drain();
  endtask

  initial begin : rsp_sink
    int hold;
    int r;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else if (hold == 0 && rsp_jitter) begin
        r = $urandom_range(0, 99);
        if (r < 70) hold = 0;
        else if (r < 95) hold = $urandom_range(1, 3);
        else hold = $urandom_range(10, 40);
      end
      out_ready <= (hold == 0);
      if (hold > 0) hold--;
    end
  end

  always @(posedge clk) begin : result_check
    rpa_rsp_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        flag_mismatch("result word with none owed", 1, 0);
      end else begin
        want = answers_due.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.alloc_frame !== want.alloc_frame)
          flag_mismatch("alloc_frame", int'(out_data.alloc_frame), int'(want.alloc_frame));
        if (out_data.ref_count !== want.ref_count)
          flag_mismatch("ref_count", int'(out_data.ref_count), int'(want.ref_count));
        if (out_data.page_freed !== want.page_freed)
          flag_mismatch("page_freed", int'(out_data.page_freed), int'(want.page_freed));
        if (out_data.free_count !== want.free_count)
          flag_mismatch("free_count", int'(out_data.free_count), int'(want.free_count));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("refcounted_page_allocator_core_tb failed");
      $finish;
    end
  end

  initial begin : run
    int i;
    for (i = 0; i < POOL_PAGES; i++) begin
      page_refs[i] = 0;
      page_link[i] = '0;
      link_set[i] = 1'b0;
    end
    head_page = '0;
    pages_free = 0;
    pool_base = '0;
    mismatches = 0;
    words_sent = 0;
    results_seen = 0;
    allocs_granted = 0;
    pages_pushed = 0;
    base_writes = 0;
    quiet_cycles = 0;
    req_jitter = 1'b0;
    rsp_jitter = 1'b0;
    rsp_hold_req = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_output_backpressure();
    test_random_mix();

    drain();
    repeat (4) @(posedge clk);
    $display("run: %0d requests, %0d results, %0d base writes incl. 0 and 0xFFFFF",
             words_sent, results_seen, base_writes);
    $display("run: %0d pages granted, %0d pages returned, empty pool, range edges and output stalls hit",
             allocs_granted, pages_pushed);
    if (mismatches == 0)
      $display("refcounted_page_allocator_core_tb passed");
    else
      $display("refcounted_page_allocator_core_tb failed");
    $finish;
  end

endmodule
